/* sv/gsp_pkg.sv */
// Shared types, constants and the exp table generator for the Gaussian site-pair force block.
package gsp_pkg;

    localparam int unsigned EXP_TABLE_BITS_DEF = 10;
    localparam logic [30:0] LOG2E_Q30 = 31'd1549082005;
    localparam logic [31:0] LN2_Q32   = 32'd2977044472;

    typedef struct packed {
        logic signed [31:0] delta_x;
        logic signed [31:0] delta_y;
        logic signed [31:0] delta_z;
        logic [16:0]        special_factor;
        logic [30:0]        center_distance;
        logic signed [31:0] well_depth;
        logic [30:0]        well_width;
        logic [30:0]        cutoff_distance;
    } t_pair_in;

    typedef struct packed {
        logic signed [31:0] force_x;
        logic signed [31:0] force_y;
        logic signed [31:0] force_z;
        logic signed [31:0] pair_energy;
        logic               in_range;
        logic               zero_distance;
    } t_pair_out;

    // 2^(-k/2^bits) in Q1.30 from a Taylor series of exp(-k*ln2/2^bits); elaboration only
    function automatic logic [30:0] pow2_point(input int unsigned k, input int unsigned bits);
        logic [63:0]        z;
        logic [63:0]        term;
        logic signed [63:0] sum;
        logic [63:0]        rnd;
        z    = (64'(k) * 64'(LN2_Q32)) >> bits;
        term = 64'h1_0000_0000;
        sum  = 64'sh1_0000_0000;
        for (int i = 1; i <= 24; i++) begin
            term = ((term * z) >> 32) / 64'(i);
            if ((i % 2) == 1) begin
                sum = sum - $signed(term);
            end else begin
                sum = sum + $signed(term);
            end
        end
        if (sum < 0) begin
            sum = '0;
        end
        rnd = ($unsigned(sum) + 64'd2) >> 2;
        return rnd[30:0];
    endfunction

endpackage

/* sv/gsp_isqrt.sv */
// Pipelined integer square root of a 64-bit radicand, one result bit per stage.
module gsp_isqrt #(
    parameter int unsigned SW = 1
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_vld,
    input  logic [63:0]   i_rad,
    input  logic [SW-1:0] i_side,
    output logic          o_vld,
    output logic [31:0]   o_root,
    output logic [SW-1:0] o_side
);
    logic [33:0]   w_rem  [33];
    logic [63:0]   w_rad  [33];
    logic [31:0]   w_root [33];
    logic [SW-1:0] w_side [33];
    logic          w_vld  [33];

    assign w_rem[0]  = '0;
    assign w_rad[0]  = i_rad;
    assign w_root[0] = '0;
    assign w_side[0] = i_side;
    assign w_vld[0]  = i_vld;

    for (genvar s = 0; s < 32; s++) begin : g_stage
        logic [33:0]   n_rem, r_rem;
        logic [31:0]   n_root, r_root;
        logic [63:0]   r_rad;
        logic [SW-1:0] r_side;
        logic          r_vld;

        always_comb begin
            logic [35:0] cat;
            logic [35:0] trial;
            cat   = {w_rem[s], w_rad[s][63:62]};
            trial = {2'b00, w_root[s], 2'b01};
            if (cat >= trial) begin
                n_rem  = 34'(cat - trial);
                n_root = {w_root[s][30:0], 1'b1};
            end else begin
                n_rem  = cat[33:0];
                n_root = {w_root[s][30:0], 1'b0};
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld <= 1'b0;
            end else begin
                r_vld <= w_vld[s];
            end
        end

        always_ff @(posedge i_clk) begin
            r_rem  <= n_rem;
            r_root <= n_root;
            r_rad  <= w_rad[s] << 2;
            r_side <= w_side[s];
        end

        assign w_rem[s+1]  = r_rem;
        assign w_root[s+1] = r_root;
        assign w_rad[s+1]  = r_rad;
        assign w_side[s+1] = r_side;
        assign w_vld[s+1]  = r_vld;
    end

    assign o_vld  = w_vld[32];
    assign o_root = w_root[32];
    assign o_side = w_side[32];

endmodule

/* sv/gsp_div.sv */
// Pipelined restoring divider, one quotient bit per stage, lanes share one divisor.
module gsp_div #(
    parameter int unsigned LANES = 1,
    parameter int unsigned NW    = 48,
    parameter int unsigned DW    = 31,
    parameter int unsigned QW    = 22,
    parameter int unsigned SW    = 1
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_vld,
    input  logic [LANES-1:0][NW-1:0]   i_num,
    input  logic [DW-1:0]              i_den,
    input  logic [SW-1:0]              i_side,
    output logic                       o_vld,
    output logic [LANES-1:0][QW-1:0]   o_quo,
    output logic [SW-1:0]              o_side
);
    // the caller keeps num < den * 2^QW, so the top part starts below den
    logic [LANES-1:0][DW:0]   w_rem  [QW+1];
    logic [LANES-1:0][QW-1:0] w_low  [QW+1];
    logic [LANES-1:0][QW-1:0] w_quo  [QW+1];
    logic [DW-1:0]            w_den  [QW+1];
    logic [SW-1:0]            w_side [QW+1];
    logic                     w_vld  [QW+1];

    for (genvar l = 0; l < LANES; l++) begin : g_init
        assign w_rem[0][l] = (DW+1)'(i_num[l] >> QW);
        assign w_low[0][l] = i_num[l][QW-1:0];
        assign w_quo[0][l] = '0;
    end
    assign w_den[0]  = i_den;
    assign w_side[0] = i_side;
    assign w_vld[0]  = i_vld;

    for (genvar s = 0; s < QW; s++) begin : g_stage
        logic [LANES-1:0][DW:0]   n_rem, r_rem;
        logic [LANES-1:0][QW-1:0] n_quo, r_quo, r_low;
        logic [DW-1:0]            r_den;
        logic [SW-1:0]            r_side;
        logic                     r_vld;

        always_comb begin
            logic [DW:0] cat;
            for (int l = 0; l < LANES; l++) begin
                cat = {w_rem[s][l][DW-1:0], w_low[s][l][QW-1]};
                if (cat >= {1'b0, w_den[s]}) begin
                    n_rem[l] = cat - {1'b0, w_den[s]};
                    n_quo[l] = {w_quo[s][l][QW-2:0], 1'b1};
                end else begin
                    n_rem[l] = cat;
                    n_quo[l] = {w_quo[s][l][QW-2:0], 1'b0};
                end
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld <= 1'b0;
            end else begin
                r_vld <= w_vld[s];
            end
        end

        always_ff @(posedge i_clk) begin
            r_rem <= n_rem;
            r_quo <= n_quo;
            for (int l = 0; l < LANES; l++) begin
                r_low[l] <= w_low[s][l] << 1;
            end
            r_den  <= w_den[s];
            r_side <= w_side[s];
        end

        assign w_rem[s+1]  = r_rem;
        assign w_low[s+1]  = r_low;
        assign w_quo[s+1]  = r_quo;
        assign w_den[s+1]  = r_den;
        assign w_side[s+1] = r_side;
        assign w_vld[s+1]  = r_vld;
    end

    assign o_vld  = w_vld[QW];
    assign o_quo  = w_quo[QW];
    assign o_side = w_side[QW];

endmodule

/* sv/gsp_exp.sv */
// Two-lane exp(-q^2/2) pipeline: square, scale by log2(e), table interpolation, shift.
module gsp_exp #(
    parameter int unsigned TB = gsp_pkg::EXP_TABLE_BITS_DEF,
    parameter int unsigned SW = 1
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_vld,
    input  logic [1:0][21:0]  i_q,
    input  logic [1:0]        i_far,
    input  logic [SW-1:0]     i_side,
    output logic              o_vld,
    output logic [1:0][30:0]  o_e,
    output logic [SW-1:0]     o_side
);
    import gsp_pkg::*;

    localparam int unsigned SH = 16 - TB;
    localparam int unsigned TN = (1 << TB) + 1;

    logic [30:0] w_tbl [TN];
    for (genvar j = 0; j < TN; j++) begin : g_tbl
        assign w_tbl[j] = pow2_point(j, TB);
    end

    logic                r_e1_vld, r_e2_vld, r_e3_vld, r_e4_vld, r_e5_vld;
    logic [SW-1:0]       r_e1_side, r_e2_side, r_e3_side, r_e4_side, r_e5_side;
    logic [1:0][26:0]    n_e1_t, r_e1_t;
    logic [1:0]          r_e1_far;
    logic [1:0][22:0]    n_e2_y, r_e2_y;
    logic [1:0]          n_e2_tail, r_e2_tail;
    logic [1:0][30:0]    n_e3_p0, r_e3_p0, n_e3_p1, r_e3_p1;
    logic [1:0][SH-1:0]  n_e3_rem, r_e3_rem;
    logic [1:0][4:0]     n_e3_n, r_e3_n, r_e4_n;
    logic [1:0]          n_e3_zero, r_e3_zero, r_e4_zero;
    logic [1:0][30:0]    n_e4_m, r_e4_m;
    logic [1:0][30:0]    n_e5_e, r_e5_e;

    always_comb begin
        logic [6:0]      nn;
        logic [TB-1:0]   k;
        logic [30:0]     dp;
        logic [30+SH:0]  pr;
        for (int l = 0; l < 2; l++) begin
            n_e1_t[l]    = 27'((44'(i_q[l]) * 44'(i_q[l])) >> 17);
            n_e2_tail[l] = r_e1_far[l] || (r_e1_t[l][26:22] != 5'd0);
            n_e2_y[l]    = 23'((53'(r_e1_t[l][21:0]) * 53'(LOG2E_Q30)) >> 30);
            nn           = r_e2_y[l][22:16];
            k            = r_e2_y[l][15:SH];
            n_e3_zero[l] = r_e2_tail[l] || (nn >= 7'd31);
            n_e3_n[l]    = nn[4:0];
            n_e3_rem[l]  = r_e2_y[l][SH-1:0];
            n_e3_p0[l]   = w_tbl[{1'b0, k}];
            n_e3_p1[l]   = w_tbl[{1'b0, k} + 1'b1];
            dp           = r_e3_p0[l] - r_e3_p1[l];
            pr           = (31+SH)'(dp) * (31+SH)'(r_e3_rem[l]);
            n_e4_m[l]    = (r_e3_p0[l] > r_e3_p1[l]) ? r_e3_p0[l] - 31'(pr >> SH)
                                                     : r_e3_p0[l];
            n_e5_e[l]    = r_e4_zero[l] ? 31'd0 : (r_e4_m[l] >> r_e4_n[l]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_e1_vld <= 1'b0;
            r_e2_vld <= 1'b0;
            r_e3_vld <= 1'b0;
            r_e4_vld <= 1'b0;
            r_e5_vld <= 1'b0;
        end else begin
            r_e1_vld <= i_vld;
            r_e2_vld <= r_e1_vld;
            r_e3_vld <= r_e2_vld;
            r_e4_vld <= r_e3_vld;
            r_e5_vld <= r_e4_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_e1_t    <= n_e1_t;
        r_e1_far  <= i_far;
        r_e1_side <= i_side;
        r_e2_y    <= n_e2_y;
        r_e2_tail <= n_e2_tail;
        r_e2_side <= r_e1_side;
        r_e3_p0   <= n_e3_p0;
        r_e3_p1   <= n_e3_p1;
        r_e3_rem  <= n_e3_rem;
        r_e3_n    <= n_e3_n;
        r_e3_zero <= n_e3_zero;
        r_e3_side <= r_e2_side;
        r_e4_m    <= n_e4_m;
        r_e4_n    <= r_e3_n;
        r_e4_zero <= r_e3_zero;
        r_e4_side <= r_e3_side;
        r_e5_e    <= n_e5_e;
        r_e5_side <= r_e4_side;
    end

    assign o_vld  = r_e5_vld;
    assign o_e    = r_e5_e;
    assign o_side = r_e5_side;

endmodule

/* sv/gaussian_site_pair_force.sv */
// Gaussian site-pair force: top level pipeline from separation vector to force and energy.
// Throughput: one pair per cycle; busy is held low, the pipeline never stalls.
// The longest parts are the 54-bit force quotient divider (54 stages), the per-axis
// unit-vector dividers (31 stages) and the square root (32 stages).
// Reset is synchronous and active low; it clears every valid bit, so no stale result leaves.
module gaussian_site_pair_force #(
    parameter int unsigned EXP_TABLE_BITS = gsp_pkg::EXP_TABLE_BITS_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               start,
    output logic               busy,
    input  gsp_pkg::t_pair_in  i_pair,
    output logic               o_valid,
    output gsp_pkg::t_pair_out o_result
);
    import gsp_pkg::*;

    localparam int unsigned SQRT_LAT = 32;
    localparam int unsigned RATIO_QW = 22;
    localparam int unsigned EXP_LAT  = 5;
    localparam int unsigned H_QW     = 54;
    localparam int unsigned U_QW     = 31;
    localparam int unsigned LAT      = 3 + SQRT_LAT + 1 + RATIO_QW + EXP_LAT + 3
                                       + H_QW + U_QW + 2;

    // per-pair context that rides along the front of the pipe
    typedef struct packed {
        logic [2:0][31:0] ad;
        logic [2:0]       dneg;
        logic [16:0]      factor;
        logic [30:0]      r0;
        logic             a_neg;
        logic [31:0]      a_mag;
        logic [30:0]      sig;
        logic [30:0]      cut;
    } t_ctx;

    typedef struct packed {
        t_ctx ctx;
        logic inr;
    } t_sq;

    typedef struct packed {
        t_ctx        ctx;
        logic        inr;
        logic [31:0] root;
        logic        dr_neg;
        logic        far;
        logic        farc;
    } t_rt;

    typedef struct packed {
        t_rt         rt;
        logic [21:0] q;
    } t_ex;

    typedef struct packed {
        logic [2:0][31:0] ad;
        logic [2:0]       dneg;
        logic [31:0]      root;
        logic             fneg;
        logic [31:0]      energy;
        logic             inr;
    } t_hs;

    typedef struct packed {
        logic [53:0] h;
        logic [2:0]  dneg;
        logic        fneg;
        logic [31:0] energy;
        logic        inr;
        logic        zd;
    } t_us;

    typedef struct packed {
        logic [2:0]  dneg;
        logic        fneg;
        logic [31:0] energy;
        logic        inr;
        logic        zd;
    } t_ms;

    function automatic logic [31:0] mag32(input logic [31:0] v);
        return v[31] ? (32'd0 - v) : v;
    endfunction

    // clamp a magnitude with sign into the signed 32-bit range
    function automatic logic [31:0] sat32(input logic [55:0] mag, input logic neg);
        if (neg) begin
            return (mag >= 56'h8000_0000) ? 32'h8000_0000 : 32'(56'd0 - mag);
        end
        return (mag > 56'h7FFF_FFFF) ? 32'h7FFF_FFFF : mag[31:0];
    endfunction

    logic w_accept;
    assign busy     = 1'b0;
    assign w_accept = start && !busy;

    // ---- stage A: magnitudes, signs, width floor ----
    t_ctx n_a_ctx, r_a_ctx;
    logic r_a_vld;

    always_comb begin
        n_a_ctx.ad[0]   = mag32(i_pair.delta_x);
        n_a_ctx.ad[1]   = mag32(i_pair.delta_y);
        n_a_ctx.ad[2]   = mag32(i_pair.delta_z);
        n_a_ctx.dneg    = {i_pair.delta_z[31], i_pair.delta_y[31], i_pair.delta_x[31]};
        n_a_ctx.factor  = i_pair.special_factor;
        n_a_ctx.r0      = i_pair.center_distance;
        n_a_ctx.a_neg   = i_pair.well_depth[31];
        n_a_ctx.a_mag   = mag32(i_pair.well_depth);
        // a zero width acts as the smallest step
        n_a_ctx.sig     = (i_pair.well_width == 31'd0) ? 31'd1 : i_pair.well_width;
        n_a_ctx.cut     = i_pair.cutoff_distance;
    end

    // ---- stage B: squares ----
    t_ctx             r_b_ctx;
    logic             r_b_vld;
    logic [2:0][63:0] n_b_sq, r_b_sq;
    logic [61:0]      n_b_cutsq, r_b_cutsq;

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            n_b_sq[i] = 64'(r_a_ctx.ad[i]) * 64'(r_a_ctx.ad[i]);
        end
        n_b_cutsq = 62'(r_a_ctx.cut) * 62'(r_a_ctx.cut);
    end

    // ---- stage C: sum and range test ----
    t_ctx        r_c_ctx;
    logic        r_c_vld;
    logic [63:0] n_c_rsq, r_c_rsq;
    logic        n_c_inr, r_c_inr;

    always_comb begin
        n_c_rsq = r_b_sq[0] + r_b_sq[1] + r_b_sq[2];
        n_c_inr = n_c_rsq < {2'b00, r_b_cutsq};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_vld <= 1'b0;
            r_b_vld <= 1'b0;
            r_c_vld <= 1'b0;
        end else begin
            r_a_vld <= w_accept;
            r_b_vld <= r_a_vld;
            r_c_vld <= r_b_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_a_ctx   <= n_a_ctx;
        r_b_ctx   <= r_a_ctx;
        r_b_sq    <= n_b_sq;
        r_b_cutsq <= n_b_cutsq;
        r_c_ctx   <= r_b_ctx;
        r_c_rsq   <= n_c_rsq;
        r_c_inr   <= n_c_inr;
    end

    // ---- square root ----
    t_sq         w_sq_in, w_sq_out;
    logic        w_sq_vld;
    logic [31:0] w_sq_root;

    assign w_sq_in.ctx = r_c_ctx;
    assign w_sq_in.inr = r_c_inr;

    gsp_isqrt #(
        .SW($bits(t_sq))
    ) u_sqrt (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_vld  (r_c_vld),
        .i_rad  (r_c_rsq),
        .i_side (w_sq_in),
        .o_vld  (w_sq_vld),
        .o_root (w_sq_root),
        .o_side (w_sq_out)
    );

    // ---- stage D: distance offsets from the well centre, far-tail tests ----
    t_rt              n_d_rt, r_d_rt;
    logic             r_d_vld;
    logic [1:0][31:0] n_d_num, r_d_num;

    always_comb begin
        logic signed [33:0] dr;
        logic signed [31:0] drc;
        logic [31:0]        adr;
        logic [30:0]        adrc;
        dr   = $signed({2'b00, w_sq_root}) - $signed({3'b000, w_sq_out.ctx.r0});
        drc  = $signed({1'b0, w_sq_out.ctx.cut}) - $signed({1'b0, w_sq_out.ctx.r0});
        adr  = dr[33] ? 32'(-dr) : dr[31:0];
        adrc = drc[31] ? 31'(-drc) : drc[30:0];
        n_d_rt.ctx    = w_sq_out.ctx;
        n_d_rt.inr    = w_sq_out.inr;
        n_d_rt.root   = w_sq_root;
        n_d_rt.dr_neg = dr[33];
        // quotient |dr|/sigma of 64 or more lands in the tail
        n_d_rt.far    = {5'd0, adr} >= {w_sq_out.ctx.sig, 6'd0};
        n_d_rt.farc   = {6'd0, adrc} >= {w_sq_out.ctx.sig, 6'd0};
        n_d_num[0]    = n_d_rt.far ? 32'd0 : adr;
        n_d_num[1]    = n_d_rt.farc ? 32'd0 : {1'b0, adrc};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_d_vld <= 1'b0;
        end else begin
            r_d_vld <= w_sq_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_d_rt  <= n_d_rt;
        r_d_num <= n_d_num;
    end

    // ---- q = |dr|/sigma for the pair and for the cutoff ----
    logic [1:0][47:0]       w_rnum;
    logic [1:0][RATIO_QW-1:0] w_rquo;
    logic                   w_r_vld;
    t_rt                    w_r_rt;

    assign w_rnum[0] = {r_d_num[0], 16'h0000};
    assign w_rnum[1] = {r_d_num[1], 16'h0000};

    gsp_div #(
        .LANES(2),
        .NW   (48),
        .DW   (31),
        .QW   (RATIO_QW),
        .SW   ($bits(t_rt))
    ) u_ratio_div (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_vld  (r_d_vld),
        .i_num  (w_rnum),
        .i_den  (r_d_rt.ctx.sig),
        .i_side (r_d_rt),
        .o_vld  (w_r_vld),
        .o_quo  (w_rquo),
        .o_side (w_r_rt)
    );

    // ---- Gaussian factor for both distances ----
    t_ex              w_ex_in, w_ex_out;
    logic             w_ex_vld;
    logic [1:0][30:0] w_e;

    assign w_ex_in.rt = w_r_rt;
    assign w_ex_in.q  = w_rquo[0];

    gsp_exp #(
        .TB(EXP_TABLE_BITS),
        .SW($bits(t_ex))
    ) u_exp (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_vld  (w_r_vld),
        .i_q    (w_rquo),
        .i_far  ({w_r_rt.farc, w_r_rt.far}),
        .i_side (w_ex_in),
        .o_vld  (w_ex_vld),
        .o_e    (w_e),
        .o_side (w_ex_out)
    );

    // ---- stage G: well magnitudes |A|*e ----
    t_ex         r_g_x;
    logic        r_g_vld;
    logic [31:0] n_g_gmag, r_g_gmag, n_g_gcmag, r_g_gcmag;

    always_comb begin
        logic [62:0] pg;
        logic [62:0] pgc;
        pg        = 63'(w_ex_out.rt.ctx.a_mag) * 63'(w_e[0]);
        pgc       = 63'(w_ex_out.rt.ctx.a_mag) * 63'(w_e[1]);
        n_g_gmag  = pg[61:30];
        n_g_gcmag = pgc[61:30];
    end

    // ---- stage H: shifted energy difference, scaled well ----
    t_ex         r_h_x;
    logic        r_h_vld;
    logic [32:0] n_h_dmag, r_h_dmag;
    logic        n_h_dneg, r_h_dneg;
    logic [31:0] n_h_gf, r_h_gf;

    always_comb begin
        logic signed [33:0] g;
        logic signed [33:0] gc;
        logic signed [33:0] diff;
        logic [48:0]        pf;
        // g is the negative of A times the Gaussian
        g        = r_g_x.rt.ctx.a_neg ? $signed({2'b00, r_g_gmag})
                                      : -$signed({2'b00, r_g_gmag});
        gc       = r_g_x.rt.ctx.a_neg ? $signed({2'b00, r_g_gcmag})
                                      : -$signed({2'b00, r_g_gcmag});
        diff     = g - gc;
        n_h_dneg = diff[33];
        n_h_dmag = diff[33] ? 33'(-diff) : diff[32:0];
        pf       = 49'(r_g_gmag) * 49'(r_g_x.rt.ctx.factor);
        n_h_gf   = pf[47:16];
    end

    // ---- stage I: energy magnitude and q*gf ----
    t_ex         r_i_x;
    logic        r_i_vld;
    logic [33:0] n_i_emag, r_i_emag;
    logic        r_i_dneg;
    logic [53:0] n_i_prod, r_i_prod;

    always_comb begin
        logic [49:0] pe;
        pe       = 50'(r_h_dmag) * 50'(r_h_x.rt.ctx.factor);
        n_i_emag = pe[49:16];
        n_i_prod = 54'(r_h_x.q) * 54'(r_h_gf);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_g_vld <= 1'b0;
            r_h_vld <= 1'b0;
            r_i_vld <= 1'b0;
        end else begin
            r_g_vld <= w_ex_vld;
            r_h_vld <= r_g_vld;
            r_i_vld <= r_h_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_g_x     <= w_ex_out;
        r_g_gmag  <= n_g_gmag;
        r_g_gcmag <= n_g_gcmag;
        r_h_x     <= r_g_x;
        r_h_dmag  <= n_h_dmag;
        r_h_dneg  <= n_h_dneg;
        r_h_gf    <= n_h_gf;
        r_i_x     <= r_h_x;
        r_i_emag  <= n_i_emag;
        r_i_dneg  <= r_h_dneg;
        r_i_prod  <= n_i_prod;
    end

    // ---- h = q*gf/sigma (fpair times r) ----
    t_hs                   w_hs_in, w_hs_out;
    logic [0:0][54:0]      w_hnum;
    logic [0:0][H_QW-1:0]  w_hquo;
    logic                  w_h_vld;

    assign w_hnum[0]       = {1'b0, r_i_prod};
    assign w_hs_in.ad      = r_i_x.rt.ctx.ad;
    assign w_hs_in.dneg    = r_i_x.rt.ctx.dneg;
    assign w_hs_in.root    = r_i_x.rt.root;
    assign w_hs_in.fneg    = (r_i_x.rt.dr_neg == r_i_x.rt.ctx.a_neg);
    assign w_hs_in.energy  = sat32(56'(r_i_emag), r_i_dneg);
    assign w_hs_in.inr     = r_i_x.rt.inr;

    gsp_div #(
        .LANES(1),
        .NW   (55),
        .DW   (31),
        .QW   (H_QW),
        .SW   ($bits(t_hs))
    ) u_h_div (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_vld  (r_i_vld),
        .i_num  (w_hnum),
        .i_den  (r_i_x.rt.ctx.sig),
        .i_side (w_hs_in),
        .o_vld  (w_h_vld),
        .o_quo  (w_hquo),
        .o_side (w_hs_out)
    );

    // ---- unit vector u = |delta|*2^30/r per axis ----
    t_us                   w_us_in, w_us_out;
    logic [2:0][61:0]      w_unum;
    logic [2:0][U_QW-1:0]  w_uquo;
    logic [31:0]           w_uden;
    logic                  w_u_vld;

    for (genvar i = 0; i < 3; i++) begin : g_unum
        assign w_unum[i] = {w_hs_out.ad[i], 30'h0};
    end
    // zero distance: divide by one and drop the force at the end
    assign w_uden         = (w_hs_out.root == 32'd0) ? 32'd1 : w_hs_out.root;
    assign w_us_in.h      = w_hquo[0];
    assign w_us_in.dneg   = w_hs_out.dneg;
    assign w_us_in.fneg   = w_hs_out.fneg;
    assign w_us_in.energy = w_hs_out.energy;
    assign w_us_in.inr    = w_hs_out.inr;
    assign w_us_in.zd     = (w_hs_out.root == 32'd0);

    gsp_div #(
        .LANES(3),
        .NW   (62),
        .DW   (32),
        .QW   (U_QW),
        .SW   ($bits(t_us))
    ) u_unit_div (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_vld  (w_h_vld),
        .i_num  (w_unum),
        .i_den  (w_uden),
        .i_side (w_us_in),
        .o_vld  (w_u_vld),
        .o_quo  (w_uquo),
        .o_side (w_us_out)
    );

    // ---- stage M: split h into integer and fraction parts times u ----
    t_ms              n_m_side, r_m_side;
    logic             r_m_vld;
    logic [2:0][54:0] n_m_hi, r_m_hi;
    logic [2:0][30:0] n_m_lo, r_m_lo;

    always_comb begin
        logic [60:0] pl;
        for (int i = 0; i < 3; i++) begin
            n_m_hi[i] = 55'(w_us_out.h[53:30]) * 55'(w_uquo[i]);
            pl        = 61'(w_us_out.h[29:0]) * 61'(w_uquo[i]);
            n_m_lo[i] = pl[60:30];
        end
        n_m_side.dneg   = w_us_out.dneg;
        n_m_side.fneg   = w_us_out.fneg;
        n_m_side.energy = w_us_out.energy;
        n_m_side.inr    = w_us_out.inr;
        n_m_side.zd     = w_us_out.zd;
    end

    // ---- output beat: sum, sign, saturate, zero outside the cutoff ----
    t_pair_out n_out, r_out;
    logic      r_out_vld;

    always_comb begin
        logic [2:0][31:0] f;
        logic [55:0]      m;
        for (int i = 0; i < 3; i++) begin
            m    = {1'b0, r_m_hi[i]} + 56'(r_m_lo[i]);
            f[i] = (r_m_side.inr && !r_m_side.zd)
                   ? sat32(m, r_m_side.fneg != r_m_side.dneg[i]) : 32'd0;
        end
        n_out.force_x       = f[0];
        n_out.force_y       = f[1];
        n_out.force_z       = f[2];
        n_out.pair_energy   = r_m_side.inr ? r_m_side.energy : 32'd0;
        n_out.in_range      = r_m_side.inr;
        n_out.zero_distance = r_m_side.inr && r_m_side.zd;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m_vld   <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            r_m_vld   <= w_u_vld;
            r_out_vld <= r_m_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_m_side <= n_m_side;
        r_m_hi   <= n_m_hi;
        r_m_lo   <= n_m_lo;
        r_out    <= n_out;
    end

    assign o_valid  = r_out_vld;
    assign o_result = r_out;

    // every result beat traces back to an accepted pair a fixed latency earlier
    a_fixed_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> $past(start && !busy, LAT))
        else $error("result beat without a matching accepted pair");

    a_out_of_range_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_result.in_range) |->
            (o_result.force_x == 32'sd0 && o_result.force_y == 32'sd0 &&
             o_result.force_z == 32'sd0 && o_result.pair_energy == 32'sd0 &&
             !o_result.zero_distance))
        else $error("out-of-range pair produced nonzero output");

    a_zero_distance_force: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_result.zero_distance) |->
            (o_result.in_range && o_result.force_x == 32'sd0 &&
             o_result.force_y == 32'sd0 && o_result.force_z == 32'sd0))
        else $error("zero-distance pair produced a force");

endmodule
